>>> hdl/nfa_pkg.sv
// Shared types, constants and ring helpers for the neighbour fork arbiter.
`default_nettype none

package nfa_pkg;

  localparam int MAX_SEATS  = 16;
  localparam int COUNT_BITS = 16;
  localparam int RING_W     = 7;
  localparam int SEAT_W     = 4;
  localparam int NS_W       = 5;
  localparam int APB_AW     = 3;

  localparam logic [NS_W-1:0]       NUM_SEATS_RST = 5'd5;
  localparam logic [APB_AW-3:0]     REG_NUM_SEATS = 1'b0;
  localparam logic                  OP_PICKUP     = 1'b0;

  typedef logic [RING_W-1:0] ring_t;

  localparam ring_t RING_MIN  = 7'd2;
  localparam ring_t RING_TRIO = 7'd3;

  typedef enum logic [1:0] {
    EV_GRANT   = 2'd0,
    EV_WAIT    = 2'd1,
    EV_RELEASE = 2'd2,
    EV_WOKEN   = 2'd3
  } ev_res_e;

  typedef struct packed {
    ev_res_e             res;
    logic [SEAT_W-1:0]   seat;
  } ev_t;

  typedef struct packed {
    logic      vld;
    logic [1:0] last_idx;
    ev_t [2:0] ev;
  } bun_t;

  // one-ahead and two-ahead comparisons of a seat against its ring neighbours
  typedef struct packed {
    logic lt1;
    logic eq1;
    logic le1;
    logic lt2;
    logic eq2;
    logic le2;
  } cmp_t;

  function automatic ring_t ring_next(ring_t i, ring_t n);
    ring_t inc;
    inc = i + 1'b1;
    return (inc >= n) ? '0 : inc;
  endfunction

  function automatic ring_t ring_prev(ring_t i, ring_t n);
    return (i == '0) ? n - 1'b1 : i - 1'b1;
  endfunction

endpackage

`default_nettype wire

>>> hdl/neighbour_fork_arbiter.sv
// Top level of the neighbour fork arbiter: config, counters, decision and result stages.
// Path: an input transfer is registered in the input register, then its results are loaded into
// the output register when it is free, and from there the first result can transfer.
// Throughput: one item per cycle while each gives at most one result and the output is not
// stalled; a putdown gives up to three results, drained one per cycle while m_axis_tready is high.
// Reset: asynchronous, clears all flags and counters at once; ring size returns to 5.
`default_nettype none

module neighbour_fork_arbiter import nfa_pkg::*; #(
  parameter int MaxSeats  = MAX_SEATS,
  parameter int CountBits = COUNT_BITS
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              s_axis_tvalid,
  output logic              s_axis_tready,
  input  logic [7:0]        s_axis_tdata,   // [3:0] seat, [7:4] zero
  input  logic              s_axis_tuser,   // [0] operation
  output logic              m_axis_tvalid,
  input  logic              m_axis_tready,
  output logic [7:0]        m_axis_tdata,   // [3:0] event_seat, [7:4] zero
  output logic [1:0]        m_axis_tuser,   // [1:0] event_res
  output logic              m_axis_tlast,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [APB_AW-1:0] paddr,
  input  logic [31:0]       pwdata,
  output logic [31:0]       prdata,
  output logic              pready
);

  ring_t               ring_n;
  cmp_t [MaxSeats-1:0] cmp;
  logic [MaxSeats-1:0] inc_use, inc_wait;
  logic                out_can;
  bun_t                bun;
  ev_res_e             res;
  logic [SEAT_W-1:0]   seat;

  nfa_cfg #(
    .MaxSeats (MaxSeats)
  ) u_cfg (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready),
    .ring_n_o (ring_n)
  );

  nfa_counts #(
    .MaxSeats  (MaxSeats),
    .CountBits (CountBits)
  ) u_counts (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .ring_n_i   (ring_n),
    .inc_use_i  (inc_use),
    .inc_wait_i (inc_wait),
    .cmp_o      (cmp)
  );

  nfa_core #(
    .MaxSeats (MaxSeats)
  ) u_core (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_vld_i   (s_axis_tvalid),
    .in_op_i    (s_axis_tuser),
    .in_seat_i  (s_axis_tdata[SEAT_W-1:0]),
    .in_rdy_o   (s_axis_tready),
    .ring_n_i   (ring_n),
    .cmp_i      (cmp),
    .out_can_i  (out_can),
    .bun_o      (bun),
    .inc_use_o  (inc_use),
    .inc_wait_o (inc_wait)
  );

  nfa_out u_out (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .bun_i     (bun),
    .out_can_o (out_can),
    .tvalid_o  (m_axis_tvalid),
    .tready_i  (m_axis_tready),
    .res_o     (res),
    .seat_o    (seat),
    .last_o    (m_axis_tlast)
  );

  assign m_axis_tdata = {4'b0000, seat};
  assign m_axis_tuser = res;

endmodule

`default_nettype wire

>>> hdl/nfa_cfg.sv
// APB register for the ring size and its clamped value.
`default_nettype none

module nfa_cfg import nfa_pkg::*; #(
  parameter int MaxSeats = MAX_SEATS
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [APB_AW-1:0] paddr,
  input  logic [31:0]       pwdata,
  output logic [31:0]       prdata,
  output logic              pready,
  output ring_t             ring_n_o
);

  logic [NS_W-1:0] ns_q, ns_d;
  logic            hit, wr;
  ring_t           ns_ext;

  assign pready = 1'b1;
  assign hit    = (paddr[APB_AW-1:2] == REG_NUM_SEATS);
  assign wr     = psel & penable & pwrite & pready & hit;
  assign ns_d   = wr ? pwdata[NS_W-1:0] : ns_q;
  assign prdata = hit ? 32'(ns_q) : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ns_q <= NUM_SEATS_RST;
    end else begin
      ns_q <= ns_d;
    end
  end

  always_comb begin
    ns_ext = RING_W'(ns_q);
    if (ns_ext < RING_MIN) begin
      ring_n_o = RING_MIN;
    end else if (ns_ext > RING_W'(MaxSeats)) begin
      ring_n_o = RING_W'(MaxSeats);
    end else begin
      ring_n_o = ns_ext;
    end
  end

endmodule

`default_nettype wire

>>> hdl/nfa_counts.sv
// Per-seat saturating use and wait counters with neighbour comparators.
`default_nettype none

module nfa_counts import nfa_pkg::*; #(
  parameter int MaxSeats  = MAX_SEATS,
  parameter int CountBits = COUNT_BITS,
  localparam int IW       = $clog2(MaxSeats)
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  ring_t               ring_n_i,
  input  logic [MaxSeats-1:0] inc_use_i,
  input  logic [MaxSeats-1:0] inc_wait_i,
  output cmp_t [MaxSeats-1:0] cmp_o
);

  logic [CountBits-1:0] use_q  [MaxSeats];
  logic [CountBits-1:0] use_d  [MaxSeats];
  logic [CountBits-1:0] wait_q [MaxSeats];
  logic [CountBits-1:0] wait_d [MaxSeats];

  always_comb begin
    for (int i = 0; i < MaxSeats; i++) begin
      use_d[i]  = use_q[i];
      wait_d[i] = wait_q[i];
      if (inc_use_i[i] && (use_q[i] != '1)) begin
        use_d[i] = use_q[i] + 1'b1;
      end
      if (inc_wait_i[i] && (wait_q[i] != '1)) begin
        wait_d[i] = wait_q[i] + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < MaxSeats; i++) begin
        use_q[i]  <= '0;
        wait_q[i] <= '0;
      end
    end else begin
      for (int i = 0; i < MaxSeats; i++) begin
        use_q[i]  <= use_d[i];
        wait_q[i] <= wait_d[i];
      end
    end
  end

  for (genvar i = 0; i < MaxSeats; i++) begin : g_cell
    ring_t          j1, j2;
    logic [IW-1:0]  a1, a2;

    assign j1 = ring_next(RING_W'(i), ring_n_i);
    assign j2 = ring_next(j1, ring_n_i);
    assign a1 = j1[IW-1:0];
    assign a2 = j2[IW-1:0];

    assign cmp_o[i].lt1 = use_q[i] <  use_q[a1];
    assign cmp_o[i].eq1 = use_q[i] == use_q[a1];
    assign cmp_o[i].le1 = wait_q[i] <= wait_q[a1];
    assign cmp_o[i].lt2 = use_q[i] <  use_q[a2];
    assign cmp_o[i].eq2 = use_q[i] == use_q[a2];
    assign cmp_o[i].le2 = wait_q[i] <= wait_q[a2];
  end

endmodule

`default_nettype wire

>>> hdl/nfa_core.sv
// Input register, holding/waiting flags and the grant and wake decision.
`default_nettype none

module nfa_core import nfa_pkg::*; #(
  parameter int MaxSeats = MAX_SEATS,
  localparam int IW      = $clog2(MaxSeats)
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_vld_i,
  input  logic                in_op_i,
  input  logic [SEAT_W-1:0]   in_seat_i,
  output logic                in_rdy_o,
  input  ring_t               ring_n_i,
  input  cmp_t [MaxSeats-1:0] cmp_i,
  input  logic                out_can_i,
  output bun_t                bun_o,
  output logic [MaxSeats-1:0] inc_use_o,
  output logic [MaxSeats-1:0] inc_wait_o
);

  logic                vld_q, op_q, go;
  logic [SEAT_W-1:0]   seat_q;
  logic [MaxSeats-1:0] hold_q, hold_d, wait_q, wait_d;
  logic [MaxSeats-1:0] oh_s, oh_r, oh_l, hold_rel, woken;
  ring_t               s_r, r_r, l_r, rr_r, ll_r;
  logic [IW-1:0]       s, r, l, rr, ll;
  logic                in_ring, rq, lq, both, pick_r, r_first, wake_r, wake_l;

  assign go       = vld_q & out_can_i;
  assign in_rdy_o = ~vld_q | go;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q  <= 1'b0;
      hold_q <= '0;
      wait_q <= '0;
    end else begin
      if (in_rdy_o) begin
        vld_q <= in_vld_i;
      end
      hold_q <= hold_d;
      wait_q <= wait_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_vld_i && in_rdy_o) begin
      op_q   <= in_op_i;
      seat_q <= in_seat_i;
    end
  end

  always_comb begin
    s_r     = RING_W'(seat_q);
    in_ring = s_r < ring_n_i;
    r_r     = ring_next(s_r, ring_n_i);
    l_r     = ring_prev(s_r, ring_n_i);
    rr_r    = ring_next(r_r, ring_n_i);
    ll_r    = ring_prev(l_r, ring_n_i);
    s       = s_r[IW-1:0];
    r       = r_r[IW-1:0];
    l       = l_r[IW-1:0];
    rr      = rr_r[IW-1:0];
    ll      = ll_r[IW-1:0];

    oh_s    = '0;
    oh_r    = '0;
    oh_l    = '0;
    oh_s[s] = 1'b1;
    oh_r[r] = 1'b1;
    oh_l[l] = 1'b1;

    // far neighbours are judged with the releasing seat already idle
    hold_rel = hold_q & ~oh_s;
    rq       = wait_q[r] & ~hold_rel[rr];
    lq       = wait_q[l] & ~hold_rel[ll];
    both     = rq & lq & (ring_n_i != RING_MIN);
    pick_r   = cmp_i[r].eq1 ? cmp_i[r].le1 : cmp_i[r].lt1;
    r_first  = cmp_i[l].lt2 | (cmp_i[l].eq2 & cmp_i[l].le2);

    wake_r = 1'b0;
    wake_l = 1'b0;
    if (both && (ring_n_i == RING_TRIO)) begin
      wake_r = pick_r;
      wake_l = ~pick_r;
    end else if (both) begin
      wake_r = 1'b1;
      wake_l = 1'b1;
    end else if (rq) begin
      wake_r = 1'b1;
    end else if (lq) begin
      wake_l = 1'b1;
    end
    woken = (wake_r ? oh_r : '0) | (wake_l ? oh_l : '0);

    bun_o      = '0;
    hold_d     = hold_q;
    wait_d     = wait_q;
    inc_use_o  = '0;
    inc_wait_o = '0;
    if (go && in_ring) begin
      bun_o.vld         = 1'b1;
      bun_o.ev[0].seat  = seat_q;
      if (op_q == OP_PICKUP) begin
        if (!hold_q[l] && !hold_q[r]) begin
          bun_o.ev[0].res = EV_GRANT;
          hold_d          = hold_q | oh_s;
          wait_d          = wait_q & ~oh_s;
        end else begin
          bun_o.ev[0].res = EV_WAIT;
          wait_d          = wait_q | oh_s;
          inc_wait_o      = oh_s;
        end
      end else begin
        bun_o.ev[0].res  = EV_RELEASE;
        hold_d           = hold_rel | woken;
        wait_d           = wait_q & ~woken;
        inc_use_o        = oh_s;
        bun_o.ev[1].res  = EV_WOKEN;
        bun_o.ev[2].res  = EV_WOKEN;
        if (wake_r && wake_l) begin
          bun_o.last_idx    = 2'd2;
          bun_o.ev[1].seat  = r_first ? SEAT_W'(r_r) : SEAT_W'(l_r);
          bun_o.ev[2].seat  = r_first ? SEAT_W'(l_r) : SEAT_W'(r_r);
        end else if (wake_r) begin
          bun_o.last_idx    = 2'd1;
          bun_o.ev[1].seat  = SEAT_W'(r_r);
        end else if (wake_l) begin
          bun_o.last_idx    = 2'd1;
          bun_o.ev[1].seat  = SEAT_W'(l_r);
        end
      end
    end
  end

endmodule

`default_nettype wire

>>> hdl/nfa_out.sv
// Result register that holds up to three events and drains one per transfer.
`default_nettype none

module nfa_out import nfa_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  bun_t              bun_i,
  output logic              out_can_o,
  output logic              tvalid_o,
  input  logic              tready_i,
  output ev_res_e           res_o,
  output logic [SEAT_W-1:0] seat_o,
  output logic              last_o
);

  logic       vld_q, take, fin;
  logic [1:0] idx_q, last_q;
  ev_t [2:0]  ev_q;
  ev_t        cur;

  assign take      = vld_q & tready_i;
  assign last_o    = (idx_q == last_q);
  assign fin       = take & last_o;
  assign out_can_o = ~vld_q | fin;
  assign tvalid_o  = vld_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
      idx_q <= '0;
    end else if (out_can_o) begin
      vld_q <= bun_i.vld;
      idx_q <= '0;
    end else if (take) begin
      idx_q <= idx_q + 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_can_o) begin
      ev_q   <= bun_i.ev;
      last_q <= bun_i.last_idx;
    end
  end

  always_comb begin
    case (idx_q)
      2'd0:    cur = ev_q[0];
      2'd1:    cur = ev_q[1];
      default: cur = ev_q[2];
    endcase
  end

  assign res_o  = cur.res;
  assign seat_o = cur.seat;

endmodule

`default_nettype wire

>>> hdl/nfa_checker.sv
// Port-level checker for the neighbour fork arbiter and its bind.
`default_nettype none

module nfa_checker import nfa_pkg::*; (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       m_axis_tvalid,
  input logic       m_axis_tready,
  input logic [7:0] m_axis_tdata,
  input logic [1:0] m_axis_tuser,
  input logic       m_axis_tlast
);

  logic mid_q;

  // high while a multi-result run has started but not finished
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mid_q <= 1'b0;
    end else if (m_axis_tvalid && m_axis_tready) begin
      mid_q <= ~m_axis_tlast;
    end
  end

  a_stall_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=>
      m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser) && $stable(m_axis_tlast))
    else $error("result changed while stalled");

  a_single_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && (m_axis_tuser == EV_GRANT || m_axis_tuser == EV_WAIT) |-> m_axis_tlast)
    else $error("pickup result not marked last");

  a_woken_in_run: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && (m_axis_tuser == EV_WOKEN) |-> mid_q)
    else $error("wake result outside a release run");

  a_run_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && (m_axis_tuser != EV_WOKEN) |-> !mid_q)
    else $error("new run started before previous run ended");

endmodule

bind neighbour_fork_arbiter nfa_checker u_nfa_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tuser  (m_axis_tuser),
  .m_axis_tlast  (m_axis_tlast)
);

`default_nettype wire
